[src/sfd_pkg.sv]
// Shared types and constants for the SBUS frame decoder.
package sfd_pkg;

  localparam int unsigned FRAME_LEN = 25;
  localparam int unsigned NUM_CH    = 16;
  localparam int unsigned CH_W      = 11;
  localparam int unsigned DATA_BYTES = 22;
  localparam int unsigned DATA_W    = DATA_BYTES * 8;

  localparam logic [4:0] LAST_POS    = 5'(FRAME_LEN - 1);
  localparam logic [4:0] FLAG_POS    = 5'd23;
  localparam logic [3:0] LAST_CH     = 4'(NUM_CH - 1);
  localparam logic [7:0] SBUS_HEADER = 8'h0F;
  localparam logic [7:0] SBUS_FOOTER = 8'h00;
  localparam int unsigned LOST_BIT     = 2;
  localparam int unsigned FAILSAFE_BIT = 3;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_word_t;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        lost_flag;
    logic        failsafe_active;
    logic        frame_status;
    logic        last_of_frame;
  } ch_word_t;

  // One decoded frame waiting to be unpacked into channels.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              lost_flag;
    logic              failsafe_active;
    logic              frame_status;
  } frame_entry_t;

endpackage

[src/sfd_front.sv]
// Front end: byte assembly, header/footer check and stale-frame filter.
module sfd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rx_valid,
  input  sfd_pkg::rx_word_t     rx_word,
  output logic                  rx_stall,
  input  logic                  q_full,
  output logic                  push,
  output sfd_pkg::frame_entry_t push_entry
);
  import sfd_pkg::*;

  logic [7:0] frame_store [FRAME_LEN];
  logic [7:0] previous_frame [FRAME_LEN];
  logic [4:0] pos;
  logic       match;

  logic       accept;
  logic [4:0] pos_eff;
  logic       match_eff;
  logic       byte_eq;
  logic       is_last;
  logic       good;
  logic       stale;

  assign rx_stall = q_full;
  assign accept   = rx_valid && !rx_stall;

  always_comb begin
    pos_eff = pos;
    if (rx_word.frame_start || pos > LAST_POS) begin
      pos_eff = '0;
    end
    match_eff = (pos_eff == '0) ? 1'b1 : match;
    byte_eq   = (rx_word.rx_byte == previous_frame[pos_eff]);
    is_last   = (pos_eff == LAST_POS);
    good      = (frame_store[0] == SBUS_HEADER) && (rx_word.rx_byte == SBUS_FOOTER);
    stale     = good && match_eff && byte_eq;
    push      = accept && is_last && !stale;
  end

  always_comb begin
    push_entry = '0;
    if (good) begin
      for (int i = 0; i < DATA_BYTES; i++) begin
        push_entry.data[i*8 +: 8] = frame_store[i+1];
      end
      push_entry.lost_flag       = frame_store[FLAG_POS][LOST_BIT];
      push_entry.failsafe_active = frame_store[FLAG_POS][FAILSAFE_BIT];
      push_entry.frame_status    = STATUS_OK;
    end else begin
      push_entry.frame_status = STATUS_BAD;
    end
  end

  // Position and running match against the last accepted frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      match <= 1'b1;
    end else if (accept) begin
      pos   <= is_last ? 5'd0 : pos_eff + 5'd1;
      match <= match_eff && byte_eq;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_store[pos_eff] <= rx_word.rx_byte;
    end
  end

  // Latch a new valid frame as the reference for the stale check.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        previous_frame[i] <= '0;
      end
    end else if (push && good) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        previous_frame[i] <= frame_store[i];
      end
      previous_frame[FRAME_LEN-1] <= rx_word.rx_byte;
    end
  end

endmodule

[src/sfd_queue.sv]
// Small frame queue between front and back ends.
module sfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sfd_pkg::frame_entry_t push_entry,
  output logic                  full,
  output logic                  q_valid,
  output sfd_pkg::frame_entry_t q_entry,
  input  logic                  pop
);
  import sfd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  frame_entry_t     entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

[src/sfd_back.sv]
// Back end: unpacks one queued frame into sixteen channel words.
module sfd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  sfd_pkg::frame_entry_t q_entry,
  output logic                  pop,
  output logic                  ch_valid,
  output sfd_pkg::ch_word_t     ch_word,
  input  logic                  ch_stall
);
  import sfd_pkg::*;

  logic [DATA_W-1:0] shreg;
  logic              lost;
  logic              fs;
  logic              status;
  logic [3:0]        cnt;
  logic              busy;
  logic              advance;

  assign advance = busy && (!ch_valid || !ch_stall);
  assign pop     = q_valid && (!busy || (advance && cnt == LAST_CH));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      ch_valid <= 1'b0;
    end else begin
      if (advance) begin
        ch_valid <= 1'b1;
        cnt      <= cnt + 4'd1;
        if (cnt == LAST_CH) begin
          busy <= 1'b0;
        end
      end else if (ch_valid && !ch_stall) begin
        ch_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  // Payload: shift one channel out per advance, reload on pop.
  always_ff @(posedge clk) begin
    if (advance) begin
      ch_word.channel_index   <= cnt;
      ch_word.channel_value   <= shreg[CH_W-1:0];
      ch_word.lost_flag       <= lost;
      ch_word.failsafe_active <= fs;
      ch_word.frame_status    <= status;
      ch_word.last_of_frame   <= (cnt == LAST_CH);
      shreg                   <= shreg >> CH_W;
    end
    if (pop) begin
      shreg  <= q_entry.data;
      lost   <= q_entry.lost_flag;
      fs     <= q_entry.failsafe_active;
      status <= q_entry.frame_status;
    end
  end

endmodule

[src/sbus_frame_decoder_unit.sv]
// A frame is queued on its last byte; channel words are registered, 16 per emitted frame.
// Throughput: one byte per cycle in and one channel word per cycle out, when not stalled.
// Input stalls only while the frame queue (QUEUE_DEPTH frames) is full behind the unpacker.
// Reset (rst, synchronous, active high): byte position 0, last-frame reference all zeros,
// queue empty, no word pending on the output.
module sbus_frame_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  input  sfd_pkg::rx_word_t  rx_word,
  output logic               rx_stall,
  output logic               ch_valid,
  output sfd_pkg::ch_word_t  ch_word,
  input  logic               ch_stall
);
  import sfd_pkg::*;

  logic         q_full;
  logic         push;
  frame_entry_t push_entry;
  logic         q_valid;
  frame_entry_t q_entry;
  logic         pop;

  // Front end: track byte position, check header and footer on the last byte,
  // drop frames identical to the last accepted one, queue the rest.
  sfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_word    (rx_word),
    .rx_stall   (rx_stall),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Hold decoded frames so byte intake and channel output stall independently.
  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  // Back end: shift out 11-bit channels LSB-first through a registered output.
  sfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .pop      (pop),
    .ch_valid (ch_valid),
    .ch_word  (ch_word),
    .ch_stall (ch_stall)
  );

endmodule
